@@ rtl/pges_pkg.sv @@
package pges_pkg;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_START = 2'd2
  } pges_cmd_e;

  typedef struct packed {
    logic done;
  } pges_status_t;

  // command field of a request
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [1:0] REG_ATT_X = 2'd0;
  localparam logic [1:0] REG_ATT_Y = 2'd1;
  localparam logic [1:0] REG_ATT_Z = 2'd2;
  localparam logic [1:0] REG_MASS  = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

@@ rtl/pges_ctrl.sv @@
module pges_ctrl import pges_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid,
  input  logic         in_cmd_i,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  output pges_cmd_e    cmd_o,
  input  pges_status_t status_i
);

  typedef enum logic [1:0] {ST_IDLE, ST_BUSY, ST_OUT} state_e;
  state_e state_q;

  assign in_stall  = (state_q == ST_BUSY) || (state_q == ST_OUT && out_stall);
  assign out_valid = (state_q == ST_OUT);

  always_comb begin
    cmd_o = CMD_NONE;
    if (in_valid && !in_stall) begin
      cmd_o = (in_cmd_i == OP_STEP) ? CMD_START : CMD_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE, ST_OUT: begin
          if (in_valid && !in_stall) begin
            state_q <= (in_cmd_i == OP_STEP) ? ST_BUSY : ST_OUT;
          end else if (state_q == ST_OUT && !out_stall) begin
            state_q <= ST_IDLE;
          end
        end
        ST_BUSY: if (status_i.done) state_q <= ST_OUT;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/pges_dp.sv @@
module pges_dp import pges_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  pges_cmd_e          cmd_i,
  input  logic signed [31:0] base_x_i,
  input  logic signed [31:0] base_y_i,
  input  logic signed [31:0] base_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  output pges_status_t       status_o,
  output logic signed [31:0] offset_x_o,
  output logic signed [31:0] offset_y_o,
  output logic signed [31:0] offset_z_o,
  output logic               singular_o
);

  localparam int SH = 2 * FRAC_BITS;
  // width of a 31x31 product shifted by SH, with no headroom
  localparam int NW = 62 + SH;

  typedef enum logic [2:0] {
    P_IDLE, P_DIFF, P_SQ, P_SQRT, P_L2, P_DIV, P_UPD
  } phase_e;

  logic signed [31:0] att_q [3];
  logic [30:0]        mass_q;
  logic signed [31:0] pos_q [3], vel_q [3], base_q [3];
  logic [31:0]        mag_q [3];
  logic [2:0]         neg_q;
  logic [65:0]        sum_q;
  logic [63:0]        rem_q, val_q;
  logic [31:0]        len_q;
  logic [63:0]        len2_q;
  logic [5:0]         cnt_q;
  logic [1:0]         ax_q;
  logic [1:0]         sub_q;
  logic [NW-1:0]      num_q, quo_q;
  logic [64:0]        r_q;
  logic [63:0]        den_q;
  logic [7:0]         bit_q;
  logic               sing_q;
  phase_e             ph_q;

  logic [64:0]        rsh;

  assign status_o.done = (ph_q == P_UPD) || (ph_q == P_DIFF && (mass_q == '0))
                         || (ph_q == P_SQRT && sum_q == '0);

  always_comb begin
    rsh = {r_q[63:0], num_q[NW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        att_q[i] <= '0; pos_q[i] <= '0; vel_q[i] <= '0; base_q[i] <= '0;
      end
      mass_q <= '0;
      ph_q <= P_IDLE;
      sing_q <= 1'b0;
      sum_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MASS) mass_q <= cfg_data_i[30:0];
        else att_q[cfg_idx_i] <= cfg_data_i;
      end
      unique case (ph_q)
        P_IDLE: begin
          if (cmd_i == CMD_LOAD) begin
            base_q[0] <= base_x_i; base_q[1] <= base_y_i; base_q[2] <= base_z_i;
            pos_q[0] <= base_x_i; pos_q[1] <= base_y_i; pos_q[2] <= base_z_i;
            vel_q[0] <= vel_x_i; vel_q[1] <= vel_y_i; vel_q[2] <= vel_z_i;
            sing_q <= 1'b0;
          end else if (cmd_i == CMD_START) begin
            sing_q <= 1'b0;
            ph_q <= P_DIFF;
          end
        end
        P_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            logic signed [33:0] dtmp;
            dtmp = 34'(sat32({{2{att_q[i][31]}}, att_q[i]} -
                             {{2{pos_q[i][31]}}, pos_q[i]}));
            neg_q[i] <= dtmp[33];
            mag_q[i] <= dtmp[33] ? 32'(-dtmp) : dtmp[31:0];
          end
          ax_q <= '0;
          sum_q <= '0;
          ph_q <= (mass_q == '0) ? P_IDLE : P_SQ;
        end
        P_SQ: begin
          sum_q <= sum_q + 66'(64'(mag_q[ax_q]) * 64'(mag_q[ax_q]));
          if (ax_q == 2'd2) begin
            ph_q <= P_SQRT;
            cnt_q <= '0;
            rem_q <= '0;
            len_q <= '0;
          end else ax_q <= ax_q + 2'd1;
        end
        P_SQRT: begin
          // one result bit per cycle, restoring
          if (sum_q == '0) begin
            sing_q <= 1'b1;
            ph_q <= P_IDLE;
          end else begin
            logic [65:0] r2, t;
            r2 = {rem_q, sum_q[65 - 2*cnt_q -: 2]};
            t  = {32'd0, len_q, 2'b01};
            if (r2 >= t) begin
              rem_q <= 64'(r2 - t);
              len_q <= {len_q[30:0], 1'b1};
            end else begin
              rem_q <= r2[63:0];
              len_q <= {len_q[30:0], 1'b0};
            end
            if (cnt_q == 6'd32) ph_q <= P_L2;
            else cnt_q <= cnt_q + 6'd1;
          end
        end
        P_L2: begin
          len2_q <= 64'(len_q) * 64'(len_q);
          ax_q <= '0;
          sub_q <= '0;
          ph_q <= P_DIV;
          bit_q <= '0;
        end
        P_DIV: begin
          if (bit_q == '0 && sub_q[0] == 1'b0) begin
            if (sub_q == 2'd0) num_q <= NW'(64'(mag_q[ax_q]) * 64'(mass_q)) << SH;
            else num_q <= quo_q;
            den_q <= (sub_q == 2'd0) ? len2_q : 64'(len_q);
            r_q <= '0;
            quo_q <= '0;
            sub_q[0] <= 1'b1;
          end else begin
            if (rsh >= {1'b0, den_q}) begin
              r_q <= rsh - {1'b0, den_q};
              quo_q <= {quo_q[NW-2:0], 1'b1};
            end else begin
              r_q <= rsh;
              quo_q <= {quo_q[NW-2:0], 1'b0};
            end
            num_q <= num_q << 1;
            if (bit_q == 8'(NW - 1)) begin
              bit_q <= '0;
              if (sub_q[1] == 1'b0) sub_q <= 2'd2;
              else begin
                logic [NW-1:0] qf;
                logic signed [33:0] a, v;
                qf = {quo_q[NW-2:0], (rsh >= {1'b0, den_q})};
                a = (qf > NW'(32'h80000000)) ? 34'sh80000000 : 34'(qf);
                if (neg_q[ax_q]) a = -a;
                v = {{2{vel_q[ax_q][31]}}, vel_q[ax_q]} + 34'(sat32(a));
                vel_q[ax_q] <= sat32(v);
                sub_q <= '0;
                if (ax_q == 2'd2) ph_q <= P_UPD;
                else ax_q <= ax_q + 2'd1;
              end
            end else bit_q <= bit_q + 8'd1;
          end
        end
        P_UPD: begin
          for (int i = 0; i < 3; i++) begin
            pos_q[i] <= sat32({{2{pos_q[i][31]}}, pos_q[i]} +
                              {{2{vel_q[i][31]}}, vel_q[i]});
          end
          ph_q <= P_IDLE;
        end
        default: ph_q <= P_IDLE;
      endcase
    end
  end

  assign offset_x_o = sat32({{2{pos_q[0][31]}}, pos_q[0]} - {{2{base_q[0][31]}}, base_q[0]});
  assign offset_y_o = sat32({{2{pos_q[1][31]}}, pos_q[1]} - {{2{base_q[1][31]}}, base_q[1]});
  assign offset_z_o = sat32({{2{pos_q[2][31]}}, pos_q[2]} - {{2{base_q[2][31]}}, base_q[2]});
  assign singular_o = sing_q;

endmodule

@@ rtl/point_gravity_euler_step.sv @@
// Point-mass gravity Euler stepper.
// Input channel: in_valid / in_stall carry one request (command plus base and
// velocity). command 0 loads base position, position and velocity; 1 runs one
// gravity step toward the configured attractor.
// Output channel: out_valid / out_stall carry one result per request: the
// position minus base on each axis and the singular flag.
// A load answers the next cycle. A step, once taken, runs one difference, three
// squares, a square root (one bit a cycle), L^2, then six divisions on the
// shared restoring divider, and one update. Zero mass answers after the
// difference, zero distance after the squares. One request is in flight at a
// time; a new one is taken in the cycle its predecessor's result is taken.
// Reset clears position, velocity, base and the attractor registers.
// A stalled result holds; while it is held no new request is taken.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) only while idle.
module point_gravity_euler_step import pges_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command_i,
  input  logic signed [31:0] base_x_i,
  input  logic signed [31:0] base_y_i,
  input  logic signed [31:0] base_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] offset_x_o,
  output logic signed [31:0] offset_y_o,
  output logic signed [31:0] offset_z_o,
  output logic               singular_o
);

  pges_cmd_e    cmd;
  pges_status_t status;

  pges_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_cmd_i(command_i), .in_stall,
    .out_valid, .out_stall, .cmd_o(cmd), .status_i(status)
  );

  pges_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .cmd_i(cmd),
    .base_x_i, .base_y_i, .base_z_i, .vel_x_i, .vel_y_i, .vel_z_i,
    .status_o(status), .offset_x_o, .offset_y_o, .offset_z_o, .singular_o
  );

  // a load reports zero offset
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall && command_i == OP_LOAD) |=>
      (out_valid && offset_x_o == 0 && offset_y_o == 0 && offset_z_o == 0 && !singular_o))
    else $error("load offset not zero");

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |-> in_stall)
    else $error("request taken while result held");

endmodule

@@ tb/point_gravity_euler_step_test.sv @@
module point_gravity_euler_step_test import pges_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC       = 16;
  localparam int  WATCHDOG   = 20000;  // cycles without any handshake
  localparam int  HOLD_OFF   = 3000;   // long receiver hold-off, in cycles
  localparam int  END_SLACK  = 50;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] SMAX = 32'h7fff_ffff;
  localparam logic [31:0] SMIN = 32'h8000_0000;
  localparam logic [31:0] MASS_MAX = 32'h7fff_ffff;

  // one request on the input channel
  typedef struct {
    logic        cmd;
    logic [31:0] base [3];
    logic [31:0] vel  [3];
  } request_t;

  // one result on the output channel
  typedef struct {
    logic [31:0] off [3];
    logic        sing;
  } offset_t;

  // directed row: optional attractor setting, the request, optional typed result
  typedef struct {
    bit          set_cfg;
    logic [31:0] att [3];
    logic [31:0] mass;
    request_t    req;
    bit          typed;
    offset_t     want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = REG_ATT_X;
  logic [31:0] cfg_data_i = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command_i = OP_LOAD;
  logic signed [31:0] base_x_i = '0, base_y_i = '0, base_z_i = '0;
  logic signed [31:0] vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [31:0] offset_x_o, offset_y_o, offset_z_o;
  logic singular_o;

  point_gravity_euler_step DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid, .in_stall, .command_i,
    .base_x_i, .base_y_i, .base_z_i, .vel_x_i, .vel_y_i, .vel_z_i,
    .out_valid, .out_stall,
    .offset_x_o, .offset_y_o, .offset_z_o, .singular_o
  );

  always #5 clk_i = ~clk_i;

  // Particle model state, kept in step with what the block has accepted.
  logic signed [31:0] att_pos [3];
  logic [30:0]        att_mass;
  logic signed [31:0] p_pos [3];
  logic signed [31:0] p_vel [3];
  logic signed [31:0] p_base [3];

  offset_t pending_offsets[$];
  row_t    rows[$];
  int      errors = 0;
  int      send_idle = 0;   // percent of cycles the sender drops valid
  int      recv_idle = 0;   // percent of cycles the receiver stalls
  int      hold_left = 0;   // long hold-off, counted down by the receiver

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r, trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  // Advances the particle by one request and returns the offsets it reports.
  function automatic offset_t advance_particle(input request_t r);
    offset_t o;
    logic signed [63:0] d [3];
    logic [63:0] mag [3];
    logic [63:0] sum, len, len2;
    logic [127:0] q;
    logic signed [63:0] accel;
    o.sing = 1'b0;
    if (r.cmd == OP_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        p_base[i] = r.base[i];
        p_pos[i]  = r.base[i];
        p_vel[i]  = r.vel[i];
      end
    end else if (att_mass != 0) begin
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        // attractor minus position, clamped before it steers anything
        d[i]   = clamp32(64'(att_pos[i]) - 64'(p_pos[i]));
        mag[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
        sum    = sum + mag[i] * mag[i];
      end
      if (sum == 0) begin
        o.sing = 1'b1;
      end else begin
        len  = floor_root(sum);
        len2 = len * len;
        for (int i = 0; i < 3; i++) begin
          q = (128'(mag[i] * 64'(att_mass))) << (2 * FRAC);
          q = q / 128'(len2);
          q = q / 128'(len);
          if (q > 128'h8000_0000) q = 128'h8000_0000;
          accel = d[i] < 0 ? -64'(q[32:0]) : 64'(q[32:0]);
          p_vel[i] = clamp32(64'(p_vel[i]) + 64'(clamp32(accel)));
        end
        for (int i = 0; i < 3; i++) p_pos[i] = clamp32(64'(p_pos[i]) + 64'(p_vel[i]));
      end
    end
    for (int i = 0; i < 3; i++) o.off[i] = clamp32(64'(p_pos[i]) - 64'(p_base[i]));
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Writes all four attractor registers; the block must be idle.
  task automatic set_attractor(input logic [31:0] x, y, z, input logic [31:0] m);
    logic [31:0] vals [4];
    logic [1:0]  idx [4];
    vals = '{x, y, z, m & MASS_MAX};
    idx  = '{REG_ATT_X, REG_ATT_Y, REG_ATT_Z, REG_MASS};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    att_pos  = '{x, y, z};
    att_mass = m[30:0];
  endtask

  task automatic wait_idle();
    while (pending_offsets.size() != 0) @(posedge clk_i);
  endtask

  // Offers one request and returns at the edge where it is taken.
  task automatic offer_request(input request_t r, input bit typed, input offset_t want);
    offset_t o;
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    command_i <= r.cmd;
    base_x_i  <= r.base[0];
    base_y_i  <= r.base[1];
    base_z_i  <= r.base[2];
    vel_x_i   <= r.vel[0];
    vel_y_i   <= r.vel[1];
    vel_z_i   <= r.vel[2];
    do @(posedge clk_i); while (in_stall);
    o = advance_particle(r);
    pending_offsets.push_back(typed ? want : o);
  endtask

  function automatic request_t make_req(input logic cmd, input logic [31:0] bx, by, bz,
                                        input logic [31:0] vx, vy, vz);
    request_t r;
    r.cmd  = cmd;
    r.base = '{bx, by, bz};
    r.vel  = '{vx, vy, vz};
    return r;
  endfunction

  function automatic void add_row(input request_t r, input bit typed = 0,
                                  input logic sing = 0);
    row_t w;
    w.set_cfg  = 0;
    w.att      = '{0, 0, 0};
    w.mass     = 0;
    w.req      = r;
    w.typed    = typed;
    w.want.off = '{0, 0, 0};
    w.want.sing = sing;
    rows.push_back(w);
  endfunction

  // attach an attractor setting to the most recent row
  function automatic void cfg_last(input logic [31:0] x, y, z, m);
    rows[$].set_cfg = 1;
    rows[$].att     = '{x, y, z};
    rows[$].mass    = m;
  endfunction

  function automatic logic [31:0] near(input int span_units);
    return $signed($urandom_range(2 * span_units * 65536)) - span_units * 65536;
  endfunction

  function automatic request_t random_request(input logic cmd);
    request_t r;
    bit noise;
    noise = $urandom_range(99) < 20;
    r.cmd = cmd;
    for (int i = 0; i < 3; i++) begin
      if (cmd == OP_STEP || noise) begin
        r.base[i] = $urandom;
        r.vel[i]  = $urandom;
      end else begin
        r.base[i] = att_pos[i] + near(300);
        r.vel[i]  = near(2);
      end
    end
    // now and then park the particle right on the attractor
    if (cmd == OP_LOAD && $urandom_range(99) < 5) begin
      r.base = att_pos;
      r.vel  = '{0, 0, 0};
    end
    return r;
  endfunction

  // Receiver: checks each result against the oldest expectation.
  always @(posedge clk_i) begin
    offset_t w;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_offsets.size() == 0) begin
        report_mismatch("unrequested result", 32'd1, 32'd0);
      end else begin
        w = pending_offsets.pop_front();
        if (offset_x_o !== w.off[0]) report_mismatch("offset_x", offset_x_o, w.off[0]);
        if (offset_y_o !== w.off[1]) report_mismatch("offset_y", offset_y_o, w.off[1]);
        if (offset_z_o !== w.off[2]) report_mismatch("offset_z", offset_z_o, w.off[2]);
        if (singular_o !== w.sing) begin
          report_mismatch("singular", 32'(singular_o), 32'(w.sing));
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= recv_idle != 0 && $urandom_range(99) < recv_idle;
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_ni) begin
      quiet = 0;
    end else if (++quiet >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    offset_t  none;
    request_t r;
    int       n;
    none.off  = '{0, 0, 0};
    none.sing = 1'b0;
    att_pos  = '{0, 0, 0};
    att_mass = '0;
    p_pos  = '{0, 0, 0};
    p_vel  = '{0, 0, 0};
    p_base = '{0, 0, 0};

    // Directed table. Zero mass after reset: nothing moves.
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0), 1);
    add_row(make_req(OP_LOAD, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN), 1);
    add_row(make_req(OP_STEP, SMIN, SMAX, 0, SMAX, SMIN, 0), 1);
    add_row(make_req(OP_LOAD, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX), 1);
    // particle sitting on the attractor: singular, no motion
    add_row(make_req(OP_LOAD, 0, 0, 0, 0, 0, 0), 1);
    cfg_last(0, 0, 0, ONE);
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0), 1, 1'b1);
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0), 1, 1'b1);
    // difference overflows 32 bits, heaviest mass
    add_row(make_req(OP_LOAD, SMAX, SMIN, SMAX, 0, 0, 0), 1);
    cfg_last(SMIN, SMAX, SMIN, MASS_MAX);
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0));
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0));
    add_row(make_req(OP_LOAD, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX), 1);
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0));
    // plain orbit-like motion
    add_row(make_req(OP_LOAD, 0, 0, 0, 0, ONE, 0), 1);
    cfg_last(10 * ONE, 0, 0, ONE);
    for (int i = 0; i < 5; i++) add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0));
    // lightest nonzero mass, very close attractor
    add_row(make_req(OP_LOAD, 0, 0, 0, 0, 0, 0), 1);
    cfg_last(1, 1, 1, 1);
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0));
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0));
    add_row(make_req(OP_LOAD, 5, -5, 5, SMAX, SMIN, 1), 1);
    add_row(make_req(OP_STEP, 0, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].set_cfg) begin
        in_valid <= 1'b0;
        wait_idle();
        set_attractor(rows[k].att[0], rows[k].att[1], rows[k].att[2], rows[k].mass);
      end
      offer_request(rows[k].req, rows[k].typed, rows[k].want);
    end

    // Random part: nine attractor settings, three idling regimes.
    for (int ph = 0; ph < 9; ph++) begin
      send_idle = ph < 3 ? 6 : (ph < 6 ? 77 : 0);
      recv_idle = ph < 3 ? 77 : (ph < 6 ? 6 : 0);
      in_valid <= 1'b0;
      wait_idle();
      case (ph)
        0: set_attractor(SMAX, SMIN, SMAX, MASS_MAX);
        1: set_attractor(near(200), near(200), near(200), 1);
        2: set_attractor($urandom, $urandom, $urandom, 0);
        3: set_attractor(SMIN, SMIN, SMAX, $urandom_range(1, 100 * 65536));
        default: set_attractor(near(200), near(200), near(200),
                               $urandom_range(1, 50 * 65536));
      endcase
      // receiver stops for a long while; the block backs up onto its input
      if (ph == 1) hold_left = HOLD_OFF;
      offer_request(random_request(OP_LOAD), 0, none);
      n = 54;
      repeat (n) begin
        r = random_request($urandom_range(99) < 12 ? OP_LOAD : OP_STEP);
        offer_request(r, 0, none);
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    repeat (END_SLACK) @(posedge clk_i);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pges_pkg.sv
rtl/pges_ctrl.sv
rtl/pges_dp.sv
rtl/point_gravity_euler_step.sv
tb/point_gravity_euler_step_test.sv
